### src/fpa_pkg.sv
// fpa_pkg: shared types, constants and action codes of the fixed-point alu
// used by every module under src; no dependencies
package fpa_pkg;

  localparam int unsigned FracBits = 8;
  localparam int unsigned WordBits = 32;
  localparam int unsigned MagBits  = WordBits;
  localparam int unsigned NumBits  = MagBits + FracBits;
  localparam int unsigned NumCells = NumBits;

  typedef enum logic [3:0] {
    ActAdd     = 4'd0,
    ActSub     = 4'd1,
    ActMul     = 4'd2,
    ActDiv     = 4'd3,
    ActGt      = 4'd4,
    ActLt      = 4'd5,
    ActGe      = 4'd6,
    ActLe      = 4'd7,
    ActEq      = 4'd8,
    ActNe      = 4'd9,
    ActMin     = 4'd10,
    ActMax     = 4'd11,
    ActInc     = 4'd12,
    ActDec     = 4'd13,
    ActFromInt = 4'd14,
    ActToInt   = 4'd15
  } action_e;

  // item travelling down the cell chain
  typedef struct packed {
    logic                        valid;
    logic                        is_div;
    logic                        dz;
    logic                        neg;
    logic signed [WordBits+1:0]  val;
    logic                        cmp;
    logic [NumBits-1:0]          num;
    logic [MagBits:0]            rem;
    logic [MagBits-1:0]          den;
  } cell_t;

endpackage

### src/fpa_front.sv
// fpa_front: first stage, decodes the action and does the non-divide operations
// and the product; the quotient is left to the divider cells; uses fpa_pkg
module fpa_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [3:0]                           action_i,
  input  logic signed [fpa_pkg::WordBits-1:0]  operand_a_i,
  input  logic signed [fpa_pkg::WordBits-1:0]  operand_b_i,
  output fpa_pkg::cell_t                       cell_o
);

  localparam int unsigned W = fpa_pkg::WordBits;
  localparam int unsigned F = fpa_pkg::FracBits;
  // out of the word range either way, clamped later
  localparam logic signed [W+1:0] Big = {2'b01, {W{1'b0}}};

  fpa_pkg::cell_t cell_d, cell_q;
  logic signed [W+1:0] a_x, b_x;
  logic [W-1:0] mag_a, mag_b;
  logic [2*W-1:0] prod;
  logic [2*W-F:0] prod_r;
  logic neg;

  always_comb begin
    a_x   = {{2{operand_a_i[W-1]}}, operand_a_i};
    b_x   = {{2{operand_b_i[W-1]}}, operand_b_i};
    mag_a = operand_a_i[W-1] ? W'(-operand_a_i) : W'(operand_a_i);
    mag_b = operand_b_i[W-1] ? W'(-operand_b_i) : W'(operand_b_i);
    neg   = operand_a_i[W-1] ^ operand_b_i[W-1];
    prod  = {{W{1'b0}}, mag_a} * {{W{1'b0}}, mag_b};
    prod_r = (2*W-F+1)'((prod >> F) + ((prod >> (F - 1)) & 1));
    cell_d = '0;
    cell_d.valid = start_i;
    cell_d.neg   = neg;
    cell_d.num   = {mag_a, F'(0)};
    cell_d.den   = mag_b;
    unique case (fpa_pkg::action_e'(action_i))
      fpa_pkg::ActAdd: cell_d.val = a_x + b_x;
      fpa_pkg::ActSub: cell_d.val = a_x - b_x;
      fpa_pkg::ActMul: begin
        if (prod_r > (2*W-F+1)'({1'b0, {W{1'b1}}})) cell_d.val = neg ? -Big : Big;
        else cell_d.val = neg ? -$signed({2'b0, prod_r[W-1:0]})
                              : $signed({2'b0, prod_r[W-1:0]});
      end
      fpa_pkg::ActDiv: begin
        cell_d.is_div = 1'b1;
        cell_d.dz     = (operand_b_i == '0);
      end
      fpa_pkg::ActGt: cell_d.cmp = operand_a_i > operand_b_i;
      fpa_pkg::ActLt: cell_d.cmp = operand_a_i < operand_b_i;
      fpa_pkg::ActGe: cell_d.cmp = operand_a_i >= operand_b_i;
      fpa_pkg::ActLe: cell_d.cmp = operand_a_i <= operand_b_i;
      fpa_pkg::ActEq: cell_d.cmp = operand_a_i == operand_b_i;
      fpa_pkg::ActNe: cell_d.cmp = operand_a_i != operand_b_i;
      fpa_pkg::ActMin: cell_d.val = (operand_a_i > operand_b_i) ? b_x : a_x;
      fpa_pkg::ActMax: cell_d.val = (operand_a_i < operand_b_i) ? b_x : a_x;
      fpa_pkg::ActInc: cell_d.val = a_x + 1;
      fpa_pkg::ActDec: cell_d.val = a_x - 1;
      fpa_pkg::ActFromInt: begin
        if (operand_a_i > $signed(W'((2**(W-1) - 1) >> F))) cell_d.val = Big;
        else if (operand_a_i < -$signed(W'(2**(W-1-F)))) cell_d.val = -Big;
        else cell_d.val = a_x <<< F;
      end
      default: cell_d.val = (operand_a_i[W-1] ? -((-a_x) >>> F) : (a_x >>> F));
    endcase
    // comparisons report value zero
    if (action_i >= 4'(fpa_pkg::ActGt) && action_i <= 4'(fpa_pkg::ActNe)) begin
      cell_d.dz = 1'b1;
      cell_d.is_div = 1'b0;
      cell_d.val = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

### src/fpa_cell.sv
// fpa_cell: one restoring-division step, one quotient bit per cell,
// other items pass through unchanged; uses fpa_pkg
module fpa_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  fpa_pkg::cell_t cell_i,
  output fpa_pkg::cell_t cell_o
);

  localparam int unsigned M = fpa_pkg::MagBits;
  localparam int unsigned N = fpa_pkg::NumBits;

  fpa_pkg::cell_t cell_d, cell_q;
  logic [M+1:0] trial;
  logic [M+1:0] shifted;

  always_comb begin
    cell_d  = cell_i;
    shifted = {cell_i.rem, cell_i.num[N-1]};
    trial   = shifted - {2'b0, cell_i.den};
    if (cell_i.is_div) begin
      if (!trial[M+1]) begin
        cell_d.rem = trial[M:0];
        cell_d.num = {cell_i.num[N-2:0], 1'b1};
      end else begin
        cell_d.rem = shifted[M:0];
        cell_d.num = {cell_i.num[N-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

### src/fpa_back.sv
// fpa_back: rounds the quotient, applies sign, clamps to the word range and
// registers the result item; uses fpa_pkg
module fpa_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  fpa_pkg::cell_t                       cell_i,
  output logic                                 done_o,
  output logic signed [fpa_pkg::WordBits-1:0]  result_o,
  output logic                                 compare_true_o,
  output logic                                 overflow_o,
  output logic                                 divide_by_zero_o
);

  localparam int unsigned W = fpa_pkg::WordBits;
  localparam int unsigned M = fpa_pkg::MagBits;
  localparam int unsigned N = fpa_pkg::NumBits;

  logic done_q;
  logic signed [W-1:0] res_d, res_q;
  logic cmp_q, ovf_d, ovf_q, dz_d, dz_q;
  logic [N:0] q_r;
  logic [M+1:0] rem_x, half_x;
  logic signed [N+1:0] sv;
  logic signed [N+1:0] hi, lo;

  always_comb begin
    rem_x  = {1'b0, cell_i.rem};
    half_x = {2'b0, cell_i.den} - rem_x;
    q_r    = {1'b0, cell_i.num} + (N+1)'(rem_x >= half_x);
    hi     = (N+2)'(2**(W-1) - 1);
    lo     = -hi - 1;
    if (cell_i.is_div && !cell_i.dz) begin
      sv = cell_i.neg ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
    end else begin
      sv = (N+2)'(cell_i.val);
    end
    dz_d  = cell_i.is_div && cell_i.dz;
    ovf_d = 1'b0;
    if (cell_i.dz) begin
      res_d = '0;
    end else if (sv > hi) begin
      res_d = hi[W-1:0];
      ovf_d = 1'b1;
    end else if (sv < lo) begin
      res_d = lo[W-1:0];
      ovf_d = 1'b1;
    end else begin
      res_d = sv[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    cmp_q <= cell_i.cmp;
    ovf_q <= ovf_d;
    dz_q  <= dz_d;
  end

  assign done_o           = done_q;
  assign result_o         = res_q;
  assign compare_true_o   = cmp_q;
  assign overflow_o       = ovf_q;
  assign divide_by_zero_o = dz_q;

endmodule

### src/fixed_point_alu.sv
// fixed_point_alu: Q-format arithmetic unit, top level; uses fpa_pkg,
// fpa_front, fpa_cell and fpa_back
// path: the front register, then the divider cell chain with one quotient bit
// per cell, then the back register; every action takes the same path
// throughput: one item per cycle, busy stays low; the receiver cannot stall
// reset: asynchronous, clears the whole cell chain and the result valid bit
module fixed_point_alu (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [3:0]                           action_i,
  input  logic signed [fpa_pkg::WordBits-1:0]  operand_a_i,
  input  logic signed [fpa_pkg::WordBits-1:0]  operand_b_i,
  output logic                                 done_o,
  output logic signed [fpa_pkg::WordBits-1:0]  result_o,
  output logic                                 compare_true_o,
  output logic                                 overflow_o,
  output logic                                 divide_by_zero_o
);

  fpa_pkg::cell_t chain [fpa_pkg::NumCells+1];

  assign busy = 1'b0;

  fpa_front u_front (
    .clk_i, .rst_ni, .start_i(start), .action_i, .operand_a_i, .operand_b_i,
    .cell_o(chain[0])
  );

  for (genvar i = 0; i < fpa_pkg::NumCells; i++) begin : g_cell
    fpa_cell u_cell (.clk_i, .rst_ni, .cell_i(chain[i]), .cell_o(chain[i+1]));
  end

  fpa_back u_back (
    .clk_i, .rst_ni, .cell_i(chain[fpa_pkg::NumCells]), .done_o, .result_o,
    .compare_true_o, .overflow_o, .divide_by_zero_o
  );

endmodule

### src/fpa_checker.sv
// fpa_checker: port-level assertions on the fixed-point alu, bound to the top
// level; uses fpa_pkg
module fpa_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 start,
  input logic                                 busy,
  input logic                                 done_o,
  input logic signed [fpa_pkg::WordBits-1:0]  result_o,
  input logic                                 compare_true_o,
  input logic                                 overflow_o,
  input logic                                 divide_by_zero_o
);

  localparam int unsigned Lat = fpa_pkg::NumCells + 2;

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##Lat done_o) else $error("item lost");
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && divide_by_zero_o) |-> (result_o == '0 && !overflow_o))
    else $error("divide by zero result");
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(compare_true_o && (overflow_o || divide_by_zero_o)))
    else $error("flags clash");

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
  .clk_i, .rst_ni, .start, .busy, .done_o, .result_o, .compare_true_o,
  .overflow_o, .divide_by_zero_o
);

### bench/tb_fixed_point_alu.sv
// tb_fixed_point_alu: self-checking bench for the fixed-point alu, predicts each
// result in exact integer arithmetic and compares it with the done_o strobe
// depends on fpa_pkg and fixed_point_alu
`timescale 1ns / 100ps

module tb_fixed_point_alu;

  localparam int unsigned WatchLimit = 2000;
  localparam int unsigned DrainCycles = fpa_pkg::NumBits + 10;

  typedef struct packed {
    logic signed [31:0] result;
    logic               compare_true;
    logic               overflow;
    logic               divide_by_zero;
  } alu_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [3:0] action_i = fpa_pkg::ActAdd;
  logic signed [31:0] operand_a_i = '0;
  logic signed [31:0] operand_b_i = '0;
  logic done_o;
  logic signed [31:0] result_o;
  logic compare_true_o;
  logic overflow_o;
  logic divide_by_zero_o;

  alu_out_t expected_q[$];
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned gap_pct = 37;

  fixed_point_alu u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .action_i(action_i), .operand_a_i(operand_a_i), .operand_b_i(operand_b_i),
    .done_o(done_o), .result_o(result_o), .compare_true_o(compare_true_o),
    .overflow_o(overflow_o), .divide_by_zero_o(divide_by_zero_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  function automatic alu_out_t alu_predict(fpa_pkg::action_e act,
                                           logic signed [31:0] a32,
                                           logic signed [31:0] b32);
    longint a, b, r, hi, lo;
    longint unsigned m, n, d, q, rm;
    bit is_cmp, cmp, dz;
    alu_out_t o;
    a = a32;
    b = b32;
    r = 0;
    is_cmp = 0;
    cmp = 0;
    dz = 0;
    hi = (64'sd1 <<< (fpa_pkg::WordBits - 1)) - 1;
    lo = -hi - 1;
    o = '0;
    case (act)
      fpa_pkg::ActAdd: r = a + b;
      fpa_pkg::ActSub: r = a - b;
      fpa_pkg::ActMul: begin
        m = magnitude(a) * magnitude(b);
        m = (m + (64'd1 << (fpa_pkg::FracBits - 1))) >> fpa_pkg::FracBits;
        r = ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
      end
      fpa_pkg::ActDiv: begin
        if (b == 0) begin
          dz = 1;
        end else begin
          n = magnitude(a) << fpa_pkg::FracBits;
          d = magnitude(b);
          q = n / d;
          rm = n % d;
          if (rm >= d - rm) q++;
          r = ((a < 0) != (b < 0)) ? -longint'(q) : longint'(q);
        end
      end
      fpa_pkg::ActGt: begin is_cmp = 1; cmp = a > b; end
      fpa_pkg::ActLt: begin is_cmp = 1; cmp = a < b; end
      fpa_pkg::ActGe: begin is_cmp = 1; cmp = a >= b; end
      fpa_pkg::ActLe: begin is_cmp = 1; cmp = a <= b; end
      fpa_pkg::ActEq: begin is_cmp = 1; cmp = a == b; end
      fpa_pkg::ActNe: begin is_cmp = 1; cmp = a != b; end
      fpa_pkg::ActMin: r = (a > b) ? b : a;
      fpa_pkg::ActMax: r = (a < b) ? b : a;
      fpa_pkg::ActInc: r = a + 1;
      fpa_pkg::ActDec: r = a - 1;
      fpa_pkg::ActFromInt: r = a * (64'sd1 <<< fpa_pkg::FracBits);
      default: r = a / (64'sd1 <<< fpa_pkg::FracBits);
    endcase
    if (is_cmp || dz) begin
      r = 0;
    end else if (r > hi) begin
      r = hi;
      o.overflow = 1'b1;
    end else if (r < lo) begin
      r = lo;
      o.overflow = 1'b1;
    end
    o.result = r[31:0];
    o.compare_true = cmp;
    o.divide_by_zero = dz;
    return o;
  endfunction

  // start stays high between items sent back to back; the idle loop lowers it
  task automatic send_item(fpa_pkg::action_e act, logic signed [31:0] a,
                           logic signed [31:0] b);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    action_i <= act;
    operand_a_i <= a;
    operand_b_i <= b;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_q.push_back(alu_predict(act, a, b));
  endtask

  function automatic logic signed [31:0] pick_operand();
    case ($urandom_range(5))
      0: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      1: return $signed($urandom_range(2047)) - 1024;
      2: return $signed($urandom_range(255)) <<< 8;
      3: return 32'($signed($urandom_range(65535)) - 32768) <<< 8;
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk_i) begin
    alu_out_t want;
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result %h", $time, result_o);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (result_o !== want.result || compare_true_o !== want.compare_true ||
            overflow_o !== want.overflow || divide_by_zero_o !== want.divide_by_zero) begin
          $display("%0t expected %h c%b o%b z%b actual %h c%b o%b z%b", $time,
                   want.result, want.compare_true, want.overflow, want.divide_by_zero,
                   result_o, compare_true_o, overflow_o, divide_by_zero_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > WatchLimit) begin
      $display("fixed_point_alu: mismatch");
      $finish;
    end
  end

  task automatic test_directed();
    logic signed [31:0] edge_vals[6];
    edge_vals = '{32'sh7fffffff, 32'sh80000000, 0, 1, -1, 32'sh100};
    for (int k = 0; k < 16; k++) begin
      send_item(fpa_pkg::action_e'(k), edge_vals[k % 6], edge_vals[(k + 1) % 6]);
    end
    send_item(fpa_pkg::ActDiv, 32'sh300, 0);
    send_item(fpa_pkg::ActMul, 32'sh180, 32'sh1);
    send_item(fpa_pkg::ActMul, -32'sh180, 32'sh1);
    send_item(fpa_pkg::ActDiv, 1, 32'sh200);
    send_item(fpa_pkg::ActDiv, 32'sh80000000, -1);
    send_item(fpa_pkg::ActInc, 32'sh7fffffff, 0);
    send_item(fpa_pkg::ActDec, 32'sh80000000, 0);
    send_item(fpa_pkg::ActToInt, -32'sh1ff, 0);
    send_item(fpa_pkg::ActEq, 5, 5);
  endtask

  task automatic test_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_item(fpa_pkg::action_e'($urandom_range(15)), pick_operand(),
                $urandom_range(15) == 0 ? 32'sd0 : pick_operand());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    gap_pct = 37;
    test_random(530);
    gap_pct = 76;
    test_random(530);
    gap_pct = 0;
    test_random(540);
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("fixed_point_alu: match");
    end else begin
      $display("fixed_point_alu: mismatch");
    end
    $finish;
  end

endmodule
